// ===== src/prm_pkg.sv =====
// Shared types, widths and the factorial table of the permutation unrank block.
`timescale 1ns / 1ps
`default_nettype none

package prm_pkg;

	localparam int LEN_W       = 5;
	localparam int RANK_W      = 45;
	localparam int VAL_W       = 5;
	localparam int FACT_W      = 64;
	localparam int MAX_LEN_DEF = 16;
	// Largest factorial that fits in FACT_W bits.
	localparam int FACT_TOP    = 20;
	localparam int FACT_N      = 2 ** LEN_W;

	typedef struct packed {
		logic [LEN_W-1:0]  length;
		logic [RANK_W-1:0] rank;
	} query_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             last;
		logic             invalid;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef logic [FACT_W-1:0] fact_tab_t [FACT_N];

	// Lengths beyond the largest representable factorial saturate to all ones.
	function automatic fact_tab_t build_fact();
		fact_tab_t tab;
		logic [FACT_W-1:0] f;
		f = FACT_W'(1);
		for (int i = 0; i < FACT_N; i++) begin
			if (i > 1) begin
				f = FACT_W'(f * FACT_W'(i));
			end
			tab[i] = (i > FACT_TOP) ? '1 : f;
		end
		return tab;
	endfunction

	localparam fact_tab_t FACT = build_fact();

endpackage

`default_nettype wire

// ===== src/prm_sub.sv =====
// Shared compare and subtract unit: remainder against the current factorial.
`timescale 1ns / 1ps
`default_nettype none

module prm_sub (
	input  wire logic [prm_pkg::RANK_W-1:0] rem,
	input  wire logic [prm_pkg::FACT_W-1:0] divisor,
	output logic                            ge,
	output logic [prm_pkg::RANK_W-1:0]      diff
);

	logic [prm_pkg::FACT_W:0] d;

	// One borrow chain gives both the compare and the reduced remainder.
	assign d    = {1'b0, prm_pkg::FACT_W'(rem)} - {1'b0, divisor};
	assign ge   = ~d[prm_pkg::FACT_W];
	assign diff = d[prm_pkg::RANK_W-1:0];

endmodule

`default_nettype wire

// ===== src/prm_list.sv =====
// Ordered list of unused values with select and remove-and-close-gap.
`timescale 1ns / 1ps
`default_nettype none

module prm_list #(
	parameter int MAX_LEN = prm_pkg::MAX_LEN_DEF,
	parameter int CNT_W   = $clog2(MAX_LEN + 1),
	parameter int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      init,
	input  wire logic [CNT_W-1:0]          count,
	input  wire logic                      remove,
	input  wire logic [IDX_W-1:0]          sel,
	output logic [prm_pkg::VAL_W-1:0]      sel_value
);

	logic [prm_pkg::VAL_W-1:0] list_q [MAX_LEN];

	assign sel_value = list_q[sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEN; i++) begin
				list_q[i] <= '0;
			end
		end else if (init) begin
			for (int i = 0; i < MAX_LEN; i++) begin
				list_q[i] <= (i < int'(count)) ? prm_pkg::VAL_W'(i + 1) : '0;
			end
		end else if (remove) begin
			// Entries from the selected one upward move down; zero enters at the top.
			for (int i = 0; i < MAX_LEN; i++) begin
				if (i >= int'(sel)) begin
					list_q[i] <= (i + 1 < MAX_LEN) ? list_q[(i + 1) % MAX_LEN] : '0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/permutation_unrank.sv =====
// Top level: sequencer that unranks a permutation one digit at a time.
`timescale 1ns / 1ps
`default_nettype none

// A query (length n, one-based rank k) is taken when start is high and busy is low.
// The block then emits the k-th lexicographic permutation of 1..n as n words, one
// per strobe, with last set on the final word; a zero rank, a rank above n!, or a
// length of zero or above MAX_LEN gives a single word with invalid and last set.
// Results cannot be held off: strobe is high for exactly one cycle per word.
// An invalid query goes from the check state straight back to idle. For a valid one,
// each word passes the load, divide and emit states, and every digit is found by
// repeated subtraction of the current factorial in one shared 64-bit subtractor.
// busy stays high until the final word is being driven.
module permutation_unrank #(
	parameter int MAX_LEN = prm_pkg::MAX_LEN_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire prm_pkg::query_t  query,
	output logic                  strobe,
	output prm_pkg::result_t      result
);

	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	prm_pkg::state_t                state_q, state_d;
	logic [prm_pkg::LEN_W-1:0]      n_q;
	logic                           zero_q;
	logic [prm_pkg::RANK_W-1:0]     rem_q;
	logic [prm_pkg::FACT_W-1:0]     bs_q;
	logic [CNT_W-1:0]               left_q;
	logic [CNT_W-1:0]               q_q;
	prm_pkg::result_t               res_q;
	logic                           strobe_q;

	logic                           accept, init, load, sub, emit_ok, emit_bad;
	logic                           ge, bad;
	logic [prm_pkg::RANK_W-1:0]     diff;
	logic [CNT_W-1:0]               cnt_full;
	logic [prm_pkg::VAL_W-1:0]      sel_value;

	prm_sub u_sub (
		.rem     (rem_q),
		.divisor (bs_q),
		.ge      (ge),
		.diff    (diff)
	);

	// A digit that reaches the number of unused entries selects the last of them.
	assign cnt_full = (q_q >= left_q) ? CNT_W'(left_q - 1'b1) : q_q;

	prm_list #(
		.MAX_LEN (MAX_LEN),
		.CNT_W   (CNT_W),
		.IDX_W   (IDX_W)
	) u_list (
		.clk       (clk),
		.arst_n    (arst_n),
		.init      (init),
		.count     (CNT_W'(n_q)),
		.remove    (emit_ok),
		.sel       (cnt_full[IDX_W-1:0]),
		.sel_value (sel_value)
	);

	// In the check state the subtractor tests k - 1 >= n!, i.e. k > n!.
	assign bad = zero_q || (n_q == '0) || (n_q > prm_pkg::LEN_W'(MAX_LEN)) || ge;

	assign busy   = (state_q != prm_pkg::ST_IDLE);
	assign strobe = strobe_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		accept   = 1'b0;
		init     = 1'b0;
		load     = 1'b0;
		sub      = 1'b0;
		emit_ok  = 1'b0;
		emit_bad = 1'b0;
		unique case (state_q)
			prm_pkg::ST_IDLE: begin
				if (start) begin
					accept  = 1'b1;
					state_d = prm_pkg::ST_CHECK;
				end
			end
			prm_pkg::ST_CHECK: begin
				if (bad) begin
					emit_bad = 1'b1;
					state_d  = prm_pkg::ST_IDLE;
				end else begin
					init    = 1'b1;
					state_d = prm_pkg::ST_LOAD;
				end
			end
			prm_pkg::ST_LOAD: begin
				load    = 1'b1;
				state_d = prm_pkg::ST_DIV;
			end
			prm_pkg::ST_DIV: begin
				if (ge) begin
					sub = 1'b1;
				end else begin
					state_d = prm_pkg::ST_EMIT;
				end
			end
			prm_pkg::ST_EMIT: begin
				emit_ok = 1'b1;
				state_d = (left_q == CNT_W'(1)) ? prm_pkg::ST_IDLE : prm_pkg::ST_LOAD;
			end
			default: begin
				state_d = prm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q      <= '0;
			zero_q   <= 1'b0;
			rem_q    <= '0;
			bs_q     <= '0;
			left_q   <= '0;
			q_q      <= '0;
			res_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit_ok || emit_bad;
			if (accept) begin
				n_q    <= query.length;
				zero_q <= (query.rank == '0);
				rem_q  <= prm_pkg::RANK_W'(query.rank - 1'b1);
				bs_q   <= prm_pkg::FACT[query.length];
			end
			if (init) begin
				left_q <= CNT_W'(n_q);
				q_q    <= '0;
			end
			if (load) begin
				bs_q <= prm_pkg::FACT[prm_pkg::LEN_W'(left_q - 1'b1)];
			end
			if (sub) begin
				rem_q <= diff;
				if (q_q != '1) begin
					q_q <= CNT_W'(q_q + 1'b1);
				end
			end
			if (emit_ok) begin
				res_q  <= '{value: sel_value, last: (left_q == CNT_W'(1)), invalid: 1'b0};
				left_q <= CNT_W'(left_q - 1'b1);
				q_q    <= '0;
			end
			if (emit_bad) begin
				res_q <= '{value: '0, last: 1'b1, invalid: 1'b1};
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after a query was taken");

	a_invalid_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.invalid |-> result.last && (result.value == '0))
		else $error("invalid word is not a single zero final word");

	a_valid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.invalid |-> (result.value != '0))
		else $error("valid word carries an empty list entry");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.last == !busy))
		else $error("busy does not match the end of the query");
`endif

endmodule

`default_nettype wire
